FILE: design/rtt_pkg.sv
// shared constants for the round-trip time estimator
`timescale 1ns / 1ps

package rtt_pkg;

    // field widths; millisecond fields count whole milliseconds
    localparam int MS_WIDTH       = 17;
    localparam int RTO_MS_WIDTH   = 18;
    localparam int RTO_SEC_WIDTH  = 8;
    localparam int RETX_WIDTH     = 4;
    localparam int COUNT_WIDTH    = 5;
    localparam int OP_WIDTH       = 2;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 17;

    localparam int DEFAULT_FRACTION_BITS = 3;

    // reset values, times in whole milliseconds
    localparam logic [MS_WIDTH-1:0]    RESET_RTO_MIN_MS  = 17'd2000;
    localparam logic [MS_WIDTH-1:0]    RESET_RTO_MAX_MS  = 17'd60000;
    localparam logic [RETX_WIDTH-1:0]  RESET_MAX_RETX    = 4'd3;
    localparam logic [MS_WIDTH-1:0]    RESET_RTT_DEV_MS  = 17'd750;
    // four deviations of 750 ms, already inside the reset clamp
    localparam logic [MS_WIDTH-1:0]    RESET_RTO_MS      = 17'd3000;
    localparam logic [MS_WIDTH-1:0]    HALF_SECOND_MS    = 17'd500;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = 5'd31;

    // x / 125 as (x * 33555) >> 22, exact for x below 2^15 + 2^14
    localparam int              DIV125_IN_WIDTH = 15;
    localparam int              DIV125_SHIFT    = 22;
    localparam logic [15:0]     DIV125_MULT     = 16'd33555;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_NEW_PACKET = 2'd0,
        OP_SAMPLE     = 2'd1,
        OP_TIMEOUT    = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_RTO_MIN  = 2'd0,
        CFG_RTO_MAX  = 2'd1,
        CFG_MAX_RETX = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_idx;

endpackage

FILE: design/rtt_in_if.sv
// event channel into the estimator
`timescale 1ns / 1ps

interface rtt_in_if
    import rtt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_WIDTH-1:0] operation;
    logic [MS_WIDTH-1:0] sample_ms;

    modport source (output valid, output operation, output sample_ms, input ready);
    modport sink   (input valid, input operation, input sample_ms, output ready);
endinterface

FILE: design/rtt_out_if.sv
// result channel out of the estimator
`timescale 1ns / 1ps

interface rtt_out_if
    import rtt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [RTO_MS_WIDTH-1:0]  rto_ms;
    logic [RTO_SEC_WIDTH-1:0] rto_seconds;
    logic                     give_up;

    modport source (output valid, output rto_ms, output rto_seconds, output give_up,
                    input ready);
    modport sink   (input valid, input rto_ms, input rto_seconds, input give_up,
                    output ready);
endinterface

FILE: design/rtt_retransmit_timer_estimator_core.sv
// retransmit timeout estimator: smoothed rtt, deviation, backoff and give-up
// a word accepted goes into the input register and then, once it moves, into the result register that drives the output
// one word per cycle while the result side does not stall; the state update and rounding fit one stage
// an input register and a result register let a new word in while a result waits
// reset (synchronous, active low) restores clamp registers, srtt 0, deviation
// 750 ms, timeout 3000 ms and a zero retransmit count
`timescale 1ns / 1ps

module rtt_retransmit_timer_estimator_core
    import rtt_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    rtt_in_if.sink                    i_in,
    rtt_out_if.source                 o_out
);

    localparam int TW        = MS_WIDTH + FRACTION_BITS;
    localparam int SW        = TW + 3;
    localparam int SEC_SHIFT = FRACTION_BITS + 3;
    localparam logic [TW-1:0] TMAX       = '1;
    localparam logic [TW-1:0] RESET_DEV  = {RESET_RTT_DEV_MS, {FRACTION_BITS{1'b0}}};
    localparam logic [TW-1:0] RESET_RTO  = {RESET_RTO_MS, {FRACTION_BITS{1'b0}}};
    localparam logic [TW:0]   HALF_MS    = (TW+1)'(1) << (FRACTION_BITS - 1);
    localparam logic [TW:0]   HALF_SEC   = {1'b0, HALF_SECOND_MS, {FRACTION_BITS{1'b0}}};

    // configuration
    logic [MS_WIDTH-1:0]    r_rto_min_ms;
    logic [MS_WIDTH-1:0]    r_rto_max_ms;
    logic [RETX_WIDTH-1:0]  r_max_retx;

    // estimator state
    logic [TW-1:0]          r_srtt;
    logic [TW-1:0]          r_rtt_dev;
    logic [TW-1:0]          r_cur_rto;
    logic [COUNT_WIDTH-1:0] r_retx_count;

    // input stage
    logic                   r_in_valid;
    t_op                    r_in_op;
    logic [MS_WIDTH-1:0]    r_in_sample;

    // result stage
    logic                     r_out_valid;
    logic [RTO_MS_WIDTH-1:0]  r_out_rto_ms;
    logic [RTO_SEC_WIDTH-1:0] r_out_rto_sec;
    logic                     r_out_give_up;

    logic move;

    logic [TW-1:0]          n_srtt;
    logic [TW-1:0]          n_rtt_dev;
    logic [TW-1:0]          n_cur_rto;
    logic [COUNT_WIDTH-1:0] n_retx_count;
    logic                   n_give_up;
    logic [RTO_MS_WIDTH-1:0]  n_rto_ms;
    logic [RTO_SEC_WIDTH-1:0] n_rto_sec;

    logic signed [SW-1:0] srtt_ext;
    logic signed [SW-1:0] dev_ext;
    logic signed [SW-1:0] meas;
    logic signed [SW-1:0] delta;
    logic signed [SW-1:0] mag;
    logic signed [SW-1:0] dev_err;
    logic signed [SW-1:0] srtt_sum;
    logic signed [SW-1:0] dev_sum;
    logic [TW-1:0]        srtt_upd;
    logic [TW-1:0]        dev_upd;
    logic [SW-1:0]        rto_raw;
    logic [SW-1:0]        rto_lo;
    logic [SW-1:0]        rto_hi;
    logic [TW-1:0]        rto_clamped;
    logic [TW-1:0]        rto_doubled;
    logic [TW:0]          ms_sum;
    logic [TW:0]          sec_sum;
    logic [DIV125_IN_WIDTH-1:0]      sec_coarse;
    logic [DIV125_IN_WIDTH+15:0]     sec_prod;

    function automatic logic [TW-1:0] sat_time(input logic signed [SW-1:0] v);
        logic [TW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > signed'({3'b000, TMAX})) begin
            res = TMAX;
        end else begin
            res = v[TW-1:0];
        end
        return res;
    endfunction

    assign move        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || move;

    assign o_out.valid       = r_out_valid;
    assign o_out.rto_ms      = r_out_rto_ms;
    assign o_out.rto_seconds = r_out_rto_sec;
    assign o_out.give_up     = r_out_give_up;

    // sample update: srtt += err/8, dev += (|err| - dev)/4, both rounding down
    always_comb begin
        srtt_ext = signed'({3'b000, r_srtt});
        dev_ext  = signed'({3'b000, r_rtt_dev});
        meas     = signed'({3'b000, r_in_sample, {FRACTION_BITS{1'b0}}});
        delta    = meas - srtt_ext;
        srtt_sum = srtt_ext + (delta >>> 3);
        srtt_upd = sat_time(srtt_sum);
        mag      = (delta < 0) ? -delta : delta;
        dev_err  = mag - dev_ext;
        dev_sum  = dev_ext + (dev_err >>> 2);
        dev_upd  = sat_time(dev_sum);

        rto_raw = {3'b000, srtt_upd} + {1'b0, dev_upd, 2'b00};
        rto_lo  = {3'b000, r_rto_min_ms, {FRACTION_BITS{1'b0}}};
        rto_hi  = {3'b000, r_rto_max_ms, {FRACTION_BITS{1'b0}}};
        // crossed bounds: a value below the minimum takes the minimum, any other the maximum
        if (rto_raw < rto_lo) begin
            rto_clamped = rto_lo[TW-1:0];
        end else if (rto_raw > rto_hi) begin
            rto_clamped = rto_hi[TW-1:0];
        end else begin
            rto_clamped = rto_raw[TW-1:0];
        end

        // backoff saturates at the top of the register, no max clamp
        rto_doubled = r_cur_rto[TW-1] ? TMAX : {r_cur_rto[TW-2:0], 1'b0};
    end

    always_comb begin
        n_srtt       = r_srtt;
        n_rtt_dev    = r_rtt_dev;
        n_cur_rto    = r_cur_rto;
        n_retx_count = r_retx_count;
        n_give_up    = 1'b0;
        unique case (r_in_op)
            OP_NEW_PACKET: begin
                n_retx_count = '0;
            end
            OP_SAMPLE: begin
                n_srtt    = srtt_upd;
                n_rtt_dev = dev_upd;
                n_cur_rto = rto_clamped;
            end
            OP_TIMEOUT: begin
                n_cur_rto = rto_doubled;
                if (r_retx_count != COUNT_MAX) begin
                    n_retx_count = r_retx_count + 1'b1;
                end
                n_give_up = n_retx_count > {1'b0, r_max_retx};
            end
            default: begin
            end
        endcase

        ms_sum     = {1'b0, n_cur_rto} + HALF_MS;
        n_rto_ms   = ms_sum[TW:FRACTION_BITS];
        // seconds: (t + 500 ms) / (1000 * 2^f steps of 2^-f ms) = ((t + 500 ms) >> (f+3)) / 125
        sec_sum    = {1'b0, n_cur_rto} + HALF_SEC;
        sec_coarse = sec_sum[TW:SEC_SHIFT];
        sec_prod   = {16'd0, sec_coarse} * {{DIV125_IN_WIDTH{1'b0}}, DIV125_MULT};
        n_rto_sec  = sec_prod[DIV125_SHIFT +: RTO_SEC_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rto_min_ms <= RESET_RTO_MIN_MS;
            r_rto_max_ms <= RESET_RTO_MAX_MS;
            r_max_retx   <= RESET_MAX_RETX;
            r_srtt       <= '0;
            r_rtt_dev    <= RESET_DEV;
            r_cur_rto    <= RESET_RTO;
            r_retx_count <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RTO_MIN:  r_rto_min_ms <= i_cfg_data[MS_WIDTH-1:0];
                    CFG_RTO_MAX:  r_rto_max_ms <= i_cfg_data[MS_WIDTH-1:0];
                    CFG_MAX_RETX: r_max_retx   <= i_cfg_data[RETX_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
            if (move) begin
                r_srtt       <= n_srtt;
                r_rtt_dev    <= n_rtt_dev;
                r_cur_rto    <= n_cur_rto;
                r_retx_count <= n_retx_count;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op     <= t_op'(i_in.operation);
            r_in_sample <= i_in.sample_ms;
        end
        if (move) begin
            r_out_rto_ms  <= n_rto_ms;
            r_out_rto_sec <= n_rto_sec;
            r_out_give_up <= n_give_up;
        end
    end

    a_new_packet_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_op == OP_NEW_PACKET) |=> (r_retx_count == '0))
        else $error("retransmit count not cleared by new packet");

    a_give_up_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_give_up) |=> (r_out_give_up && r_retx_count != '0))
        else $error("give up reported without retransmissions");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both stages are held");

endmodule

FILE: test/rtt_estimator_checker.sv
// checker for the rtt estimator: tracks state and limits, predicts every report and compares
`timescale 1ns / 1ps

module rtt_estimator_checker
    import rtt_pkg::*;
#(
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    rtt_in_if                         i_event,
    rtt_out_if                        i_result,
    output int                        o_fail_count,
    output int                        o_checked_count,
    output int                        o_pending_count
);

    localparam int     TIME_WIDTH = MS_WIDTH + FRACTION_BITS;
    localparam longint TIME_MAX   = (longint'(1) << TIME_WIDTH) - 1;
    localparam longint ONE_MS     = longint'(1) << FRACTION_BITS;

    typedef struct packed {
        logic [RTO_MS_WIDTH-1:0]  rto_ms;
        logic [RTO_SEC_WIDTH-1:0] rto_seconds;
        logic                     give_up;
    } rto_report_t;

    // estimator state and limits; the three times are scaled by 2^FRACTION_BITS
    longint                 smoothed_rtt;
    longint                 rtt_variation;
    longint                 retx_timeout;
    int                     retx_count;
    logic [MS_WIDTH-1:0]    floor_ms;
    logic [MS_WIDTH-1:0]    ceiling_ms;
    logic [RETX_WIDTH-1:0]  retx_limit;

    rto_report_t expected_reports[$];
    int          fail_total    = 0;
    int          checked_total = 0;
    int          pending_total = 0;

    assign o_fail_count    = fail_total;
    assign o_checked_count = checked_total;
    assign o_pending_count = pending_total;

    function automatic longint saturate_time(longint value);
        if (value < 0) begin
            return 0;
        end
        if (value > TIME_MAX) begin
            return TIME_MAX;
        end
        return value;
    endfunction

    // lower bound tested first: when the bounds cross, a value below it takes the lower bound, any other the upper
    function automatic longint clamp_timeout(longint value);
        longint lower_bound;
        longint upper_bound;
        lower_bound = longint'(floor_ms) * ONE_MS;
        upper_bound = longint'(ceiling_ms) * ONE_MS;
        if (value < lower_bound) begin
            value = lower_bound;
        end else if (value > upper_bound) begin
            value = upper_bound;
        end
        return saturate_time(value);
    endfunction

    function automatic void restore_reset_state();
        floor_ms      = RESET_RTO_MIN_MS;
        ceiling_ms    = RESET_RTO_MAX_MS;
        retx_limit    = RESET_MAX_RETX;
        smoothed_rtt  = 0;
        rtt_variation = longint'(RESET_RTT_DEV_MS) * ONE_MS;
        retx_count    = 0;
        retx_timeout  = clamp_timeout(smoothed_rtt + 4 * rtt_variation);
    endfunction

    function automatic rto_report_t apply_event(t_op op, logic [MS_WIDTH-1:0] sample);
        longint      measured;
        longint      delta;
        longint      magnitude;
        rto_report_t report;
        report.give_up = 1'b0;
        case (op)
            OP_NEW_PACKET: begin
                retx_count = 0;
            end
            OP_SAMPLE: begin
                measured = longint'(sample) * ONE_MS;
                delta = measured - smoothed_rtt;
                // arithmetic shifts round towards minus infinity
                smoothed_rtt = saturate_time(smoothed_rtt + (delta >>> 3));
                magnitude = (delta < 0) ? -delta : delta;
                rtt_variation = saturate_time(rtt_variation + ((magnitude - rtt_variation) >>> 2));
                retx_timeout = clamp_timeout(smoothed_rtt + 4 * rtt_variation);
            end
            OP_TIMEOUT: begin
                // backoff saturates at the register top, no upper clamp
                retx_timeout = saturate_time(retx_timeout * 2);
                if (retx_count < int'(COUNT_MAX)) begin
                    retx_count++;
                end
                report.give_up = (retx_count > int'(retx_limit));
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
        report.rto_ms      = RTO_MS_WIDTH'((retx_timeout + ONE_MS / 2) >> FRACTION_BITS);
        report.rto_seconds = RTO_SEC_WIDTH'((retx_timeout + longint'(HALF_SECOND_MS) * ONE_MS)
                                            / (1000 * ONE_MS));
        return report;
    endfunction

    function automatic void compare_field(string field, int expected_value, int actual_value);
        if (expected_value != actual_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                     expected_value, actual_value);
            fail_total++;
        end
    endfunction

    initial begin
        restore_reset_state();
    end

    always @(posedge i_clk) begin
        rto_report_t oldest;
        if (!i_rst_n) begin
            restore_reset_state();
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RTO_MIN:  floor_ms   = i_cfg_data[MS_WIDTH-1:0];
                    CFG_RTO_MAX:  ceiling_ms = i_cfg_data[MS_WIDTH-1:0];
                    CFG_MAX_RETX: retx_limit = i_cfg_data[RETX_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual rto_ms %0d",
                             $time, i_result.rto_ms);
                    fail_total++;
                end else begin
                    oldest = expected_reports.pop_front();
                    compare_field("rto_ms", oldest.rto_ms, i_result.rto_ms);
                    compare_field("rto_seconds", oldest.rto_seconds, i_result.rto_seconds);
                    compare_field("give_up", oldest.give_up, i_result.give_up);
                    checked_total++;
                end
            end
            if (i_event.valid && i_event.ready) begin
                expected_reports.push_back(apply_event(t_op'(i_event.operation),
                                                       i_event.sample_ms));
            end
        end
        pending_total = expected_reports.size();
    end

endmodule

FILE: test/rtt_retransmit_timer_estimator_core_test.sv
// testbench top for the rtt estimator: event stimulus, register phases, backpressure, verdict
`timescale 1ns / 1ps

module rtt_retransmit_timer_estimator_core_test
    import rtt_pkg::*;
;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int PHASE_EVENTS     = 400;
    localparam int MS_TOP           = (1 << MS_WIDTH) - 1;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    int fail_count;
    int checked_count;
    int pending_count;

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int hold_asks  = 0;
    int holds_done = 0;
    int events_sent = 0;
    int reg_writes  = 0;
    int quiet_cycles = 0;

    rtt_in_if  in_ch();
    rtt_out_if out_ch();

    rtt_retransmit_timer_estimator_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    rtt_estimator_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_event         (in_ch),
        .i_result        (out_ch),
        .o_fail_count    (fail_count),
        .o_checked_count (checked_count),
        .o_pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // no progress on either channel for too long ends the run
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_asks) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_event(t_op op, logic [MS_WIDTH-1:0] sample);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.sample_ms <= sample;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        events_sent++;
    endtask

    // every word yields a report, so an empty queue means the block is idle
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_limits(logic [MS_WIDTH-1:0] min_ms, logic [MS_WIDTH-1:0] max_ms,
                                  logic [RETX_WIDTH-1:0] retx);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RTO_MIN;
        cfg_data  <= min_ms;
        @(negedge clk);
        cfg_index <= CFG_RTO_MAX;
        cfg_data  <= max_ms;
        @(negedge clk);
        cfg_index <= CFG_MAX_RETX;
        cfg_data  <= CFG_DATA_WIDTH'(retx);
        @(negedge clk);
        // unused index must leave everything alone
        cfg_index <= CFG_UNUSED;
        cfg_data  <= CFG_DATA_WIDTH'($urandom_range(MS_TOP));
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes += 4;
    endtask

    function automatic logic [MS_WIDTH-1:0] pick_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return MS_WIDTH'($urandom_range(4000));
        end else if (pick < 90) begin
            return MS_WIDTH'($urandom_range(MS_TOP));
        end else begin
            return ($urandom_range(1) != 0) ? MS_WIDTH'(MS_TOP) : '0;
        end
    endfunction

    task automatic send_random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_event(OP_SAMPLE, pick_sample());
        end else if (pick < 65) begin
            send_event(OP_NEW_PACKET, MS_WIDTH'($urandom_range(MS_TOP)));
        end else if (pick < 95) begin
            send_event(OP_TIMEOUT, MS_WIDTH'($urandom_range(MS_TOP)));
        end else begin
            send_event(OP_NONE, MS_WIDTH'($urandom_range(MS_TOP)));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, logic [MS_WIDTH-1:0] min_ms,
                             logic [MS_WIDTH-1:0] max_ms, logic [RETX_WIDTH-1:0] retx,
                             bit with_hold);
        int phase_start;
        int storm_len;
        bit hold_asked;
        hold_asked = 1'b0;
        wait_for_idle();
        program_limits(min_ms, max_ms, retx);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        phase_start = events_sent;
        while (events_sent - phase_start < PHASE_EVENTS) begin
            if (with_hold && !hold_asked && events_sent - phase_start >= 100) begin
                hold_asks++;
                hold_asked = 1'b1;
            end
            if ($urandom_range(199) == 0) begin
                // backoff run long enough to saturate the retransmit count
                storm_len = $urandom_range(40, 32);
                repeat (storm_len) send_event(OP_TIMEOUT, pick_sample());
            end else begin
                send_random_event();
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_RTO_MIN;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.sample_ms = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits: report of the reset timeout, backoff past the limit
        send_event(OP_NONE, '0);
        repeat (5) send_event(OP_TIMEOUT, '0);
        send_event(OP_NEW_PACKET, MS_WIDTH'(MS_TOP));
        // zero, full-scale and falling samples, upper clamp
        send_event(OP_SAMPLE, '0);
        send_event(OP_SAMPLE, MS_WIDTH'(MS_TOP));
        send_event(OP_SAMPLE, '0);
        send_event(OP_SAMPLE, MS_WIDTH'(1));
        send_event(OP_SAMPLE, MS_WIDTH'(MS_TOP));
        send_event(OP_SAMPLE, MS_WIDTH'(MS_TOP));
        // doubling runs into the register top
        repeat (7) send_event(OP_TIMEOUT, '0);
        send_event(OP_NONE, MS_WIDTH'(MS_TOP));
        send_event(OP_NEW_PACKET, '0);
        // crossed bounds, the minimum tested first; zero retries gives up at once
        wait_for_idle();
        program_limits(MS_WIDTH'(MS_TOP), '0, '0);
        send_event(OP_SAMPLE, MS_WIDTH'(5));
        send_event(OP_TIMEOUT, '0);
        send_event(OP_NEW_PACKET, '0);

        run_phase(0, 0, RESET_RTO_MIN_MS, RESET_RTO_MAX_MS, RESET_MAX_RETX, 1'b1);
        run_phase(61, 0, '0, MS_WIDTH'(MS_TOP), 4'd15, 1'b0);
        run_phase(0, 61, MS_WIDTH'($urandom_range(3000)), MS_WIDTH'($urandom_range(MS_TOP, 1000)),
                  RETX_WIDTH'($urandom_range(15)), 1'b0);
        run_phase(14, 14, MS_WIDTH'($urandom_range(MS_TOP)), MS_WIDTH'($urandom_range(MS_TOP)),
                  RETX_WIDTH'($urandom_range(15)), 1'b0);

        wait_for_idle();
        repeat (10) @(negedge clk);
        $display("covered %0d events, %0d register writes, crossed and extreme limits,",
                 events_sent, reg_writes);
        $display("backoff saturation and four handshake phases; %0d reports checked",
                 checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
